[design/sfr_pkg.sv]
// Package for the serial frame receiver.
// Holds the result record, status codes and queue sizing; no dependencies.
package sfr_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_GOOD      = 2'd0;
    localparam logic [1:0] ST_SIZE_ERR  = 2'd1;
    localparam logic [1:0] ST_CHECK_ERR = 2'd2;

    localparam logic [7:0] START_BYTE_RESET = 8'd2;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] command;
        logic [7:0] data_high;
        logic [7:0] data_low;
        logic [1:0] data_count;
    } result_t;

endpackage

[design/sfr_if.sv]
// Channel interfaces for the serial frame receiver: received bytes and results.
// Valid/ready handshake; no package dependency.
interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] command;
    logic [7:0] data_high;
    logic [7:0] data_low;
    logic [1:0] data_count;

    modport source (output valid, output status, output command, output data_high,
                    output data_low, output data_count, input ready);
    modport sink   (input valid, input status, input command, input data_high,
                    input data_low, input data_count, output ready);
endinterface

[design/serial_frame_receiver_top.sv]
// Top level of the serial frame receiver: parser, result queue, output stage.
// Depends on sfr_pkg, sfr_if, sfr_parser, sfr_queue, sfr_out_stage.
//
//   channel  | dir | handshake            | payload
//   rx       | in  | valid/ready          | rx_byte[7:0]
//   frame    | out | valid/ready          | status, command, data_high, data_low, data_count
//   cfg      | in  | cfg_wr_en, no wait   | cfg_wr_data[7:0] -> start byte
//
// One byte is taken per cycle unless the queue is full; after the check byte or the
// offending data-position byte, a result goes via a queue slot to the output register.
// rx.ready drops only while the two-entry result queue is full.
// Reset sets the start byte to 2 and the parser to hunting; no clearing pass.
module serial_frame_receiver_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    sfr_byte_if.sink      rx,
    sfr_result_if.source  frame
);
    import sfr_pkg::*;

    logic [7:0] start_byte_reg;
    logic       byte_fire;
    logic       res_push;
    result_t    res_data;
    logic       q_full;
    logic       q_pop;
    logic       q_not_empty;
    result_t    q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_byte_reg <= START_BYTE_RESET;
        else if (cfg_wr_en)
            start_byte_reg <= cfg_wr_data;
    end

    assign rx.ready  = !q_full;
    assign byte_fire = rx.valid && rx.ready;

    sfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_byte (start_byte_reg),
        .byte_fire  (byte_fire),
        .rx_byte    (rx.rx_byte),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    sfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    sfr_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .frame       (frame)
    );

endmodule

[design/sfr_parser.sv]
// Front end: accepts received bytes, tracks the frame and classifies it.
// Depends on sfr_pkg; pushes finished results into the result queue.
module sfr_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      start_byte,
    input  logic            byte_fire,
    input  logic [7:0]      rx_byte,
    output logic            res_push,
    output sfr_pkg::result_t res_data
);
    import sfr_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_SIZE = 2'd1;
    localparam logic [1:0] PH_CMD  = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [1:0] size_reg, size_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] check_reg, check_next;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        size_next      = size_reg;
        command_next   = command_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        check_next     = check_reg;
        res_push       = 1'b0;
        res_data       = '{status: ST_GOOD, command: command_reg, data_high: high_reg,
                           data_low: low_reg, data_count: size_reg - 2'd1};
        if (byte_fire)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_byte)
                        phase_next = PH_SIZE;
                end
                PH_SIZE:
                begin
                    size_next      = rx_byte[1:0];
                    remaining_next = rx_byte;
                    check_next     = check_reg ^ rx_byte;
                    phase_next     = PH_CMD;
                end
                PH_CMD:
                begin
                    command_next   = rx_byte;
                    remaining_next = remaining_reg - 8'd1;
                    check_next     = check_reg ^ rx_byte;
                    phase_next     = PH_BODY;
                end
                default:
                begin
                    if (remaining_reg == 8'd2)
                    begin
                        high_next      = rx_byte;
                        remaining_next = 8'd1;
                        check_next     = check_reg ^ rx_byte;
                    end
                    else if (remaining_reg == 8'd1)
                    begin
                        low_next       = rx_byte;
                        remaining_next = 8'd0;
                        check_next     = check_reg ^ rx_byte;
                    end
                    else
                    begin
                        res_push = 1'b1;
                        if (remaining_reg != 8'd0)
                        begin
                            res_data.status     = ST_SIZE_ERR;
                            res_data.data_high  = 8'd0;
                            res_data.data_low   = 8'd0;
                            res_data.data_count = 2'd0;
                        end
                        else if (rx_byte != check_reg)
                        begin
                            res_data.status = ST_CHECK_ERR;
                        end
                        // rearm
                        phase_next     = PH_HUNT;
                        remaining_next = 8'd0;
                        size_next      = 2'd0;
                        command_next   = 8'd0;
                        high_next      = 8'd0;
                        low_next       = 8'd0;
                        check_next     = 8'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= 8'd0;
            size_reg      <= 2'd0;
            command_reg   <= 8'd0;
            high_reg      <= 8'd0;
            low_reg       <= 8'd0;
            check_reg     <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            size_reg      <= size_next;
            command_reg   <= command_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            check_reg     <= check_next;
        end
    end

    a_rearm_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (phase_reg == PH_HUNT && check_reg == 8'd0 && remaining_reg == 8'd0))
        else $error("parser did not rearm after a result");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_data.status == ST_GOOD || res_data.status == ST_SIZE_ERR ||
                      res_data.status == ST_CHECK_ERR))
        else $error("illegal status pushed");

    a_push_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (byte_fire && phase_reg == PH_BODY))
        else $error("result pushed outside frame body");

endmodule

[design/sfr_queue.sv]
// Short result queue between the parser and the output stage.
// Depends on sfr_pkg for the result record and the depth.
module sfr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfr_pkg::result_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output sfr_pkg::result_t pop_data
);
    import sfr_pkg::*;

    result_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count overrun");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue lost a push");

endmodule

[design/sfr_out_stage.sv]
// Back end: output register that drains the result queue onto the result channel.
// Depends on sfr_pkg and sfr_result_if.
module sfr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  sfr_pkg::result_t  q_data,
    output logic              q_pop,
    sfr_result_if.source      frame
);
    import sfr_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign q_pop = q_not_empty && (!valid_reg || frame.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (frame.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_data;
    end

    assign frame.valid      = valid_reg;
    assign frame.status     = data_reg.status;
    assign frame.command    = data_reg.command;
    assign frame.data_high  = data_reg.data_high;
    assign frame.data_low   = data_reg.data_low;
    assign frame.data_count = data_reg.data_count;

    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> valid_reg)
        else $error("output register empty after pop");

    a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !frame.ready) |-> !q_pop)
        else $error("pop while output stalled");

endmodule
